// File: hw/rtl/prbg_pkg.sv
// Shared types and constants for the pattern random byte generator.
// Used by the channel interfaces and the top level; depends on nothing.
package prbg_pkg;

  localparam int TABLE_DEPTH_DEF = 1024;  // default pattern table depth
  localparam int BYTE_W          = 8;
  localparam int BYTE_ALL_ONES   = 255;
  localparam int PTR_W           = 11;    // set pointer width, wraps
  localparam int TADDR_W         = 10;    // table address field width
  localparam int LEFT_W          = 16;    // bytes_left field width
  localparam int CFG_DATA_W      = 32;
  localparam int CFG_ADDR_W      = 4;     // four registers at 4-byte stride

  typedef logic [BYTE_W-1:0]  byte_t;
  typedef logic [PTR_W-1:0]   ptr_t;
  typedef logic [TADDR_W-1:0] taddr_t;
  typedef logic [LEFT_W-1:0]  left_t;

  // Register indexes, taken from the word address of the config port
  typedef enum logic [1:0] {
    REG_FIRST_SET_ADDR = 2'd0,
    REG_REPEAT_ADDR    = 2'd1,
    REG_SUFFIX_ADDR    = 2'd2,
    REG_SUFFIX_SETS    = 2'd3
  } reg_idx_t;

  // Input item actions
  typedef enum logic {
    ACT_LOAD     = 1'b0,
    ACT_GENERATE = 1'b1
  } action_t;

endpackage

// File: hw/rtl/prbg_if.sv
// Valid/ready channel interfaces for the pattern random byte generator:
// the input item channel and the generated byte channel. Uses prbg_pkg.
interface prbg_in_if;
  logic             valid;
  logic             ready;
  logic             action;
  prbg_pkg::taddr_t table_addr;
  prbg_pkg::byte_t  table_data;
  prbg_pkg::byte_t  draw;
  logic             first;
  prbg_pkg::left_t  bytes_left;

  modport source (output valid, action, table_addr, table_data, draw, first,
                  bytes_left, input ready);
  modport sink   (input valid, action, table_addr, table_data, draw, first,
                  bytes_left, output ready);
endinterface

interface prbg_out_if;
  logic            valid;
  logic            ready;
  prbg_pkg::byte_t data_byte;

  modport source (output valid, data_byte, input ready);
  modport sink   (input valid, data_byte, output ready);
endinterface

// File: hw/rtl/pattern_random_byte_generator_unit.sv
// Pattern random byte generator top level: pattern table memory, pointer
// pipeline, output buffer and APB-style register port.
// Depends on prbg_pkg and the channel interfaces in prbg_if.sv.

// A load item writes one table byte. For a generate item, the count byte
// at the set pointer is read from the table memory in the cycle after
// acceptance, and the pointer for the next item follows from that count,
// so the next item is taken only once the count stage is done. The member
// byte is read on a second read port of the same memory in the cycle after
// the count, before the next item's count is read, and a generated byte
// passes from the member stage into a two-entry output buffer that lets the
// block keep accepting while a byte waits. No clearing pass is run after
// reset. TABLE_DEPTH must be a power of two; table addresses wrap modulo
// the depth.
module pattern_random_byte_generator_unit #(
  parameter int TABLE_DEPTH = prbg_pkg::TABLE_DEPTH_DEF
) (
  input  logic                                clk,
  input  logic                                rst_n,
  prbg_in_if.sink                             in_ch,
  prbg_out_if.source                          out_ch,
  input  logic                                cfg_psel,
  input  logic                                cfg_penable,
  input  logic                                cfg_pwrite,
  input  logic [prbg_pkg::CFG_ADDR_W-1:0]     cfg_paddr,
  input  logic [prbg_pkg::CFG_DATA_W-1:0]     cfg_pwdata,
  output logic [prbg_pkg::CFG_DATA_W-1:0]     cfg_prdata,
  output logic                                cfg_pready
);

  localparam int AW     = $clog2(TABLE_DEPTH);
  localparam int SUM_W  = prbg_pkg::PTR_W + 1;
  localparam int WIDE_W = (AW > SUM_W) ? AW : SUM_W;

  typedef logic [AW-1:0] maddr_t;

  // ---------------- configuration registers ----------------
  logic [prbg_pkg::TADDR_W-1:0] first_set_addr_r;
  logic [prbg_pkg::TADDR_W-1:0] repeat_addr_r;
  prbg_pkg::ptr_t               suffix_addr_r;
  prbg_pkg::ptr_t               suffix_sets_r;
  prbg_pkg::reg_idx_t           cfg_idx;
  logic                         cfg_wr;

  assign cfg_pready = 1'b1;
  assign cfg_idx    = prbg_pkg::reg_idx_t'(cfg_paddr[3:2]);
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      first_set_addr_r <= '0;
      repeat_addr_r    <= '0;
      suffix_addr_r    <= prbg_pkg::ptr_t'(1);
      suffix_sets_r    <= '0;
    end else if (cfg_wr) begin
      unique case (cfg_idx)
        prbg_pkg::REG_FIRST_SET_ADDR: first_set_addr_r <= cfg_pwdata[prbg_pkg::TADDR_W-1:0];
        prbg_pkg::REG_REPEAT_ADDR:    repeat_addr_r    <= cfg_pwdata[prbg_pkg::TADDR_W-1:0];
        prbg_pkg::REG_SUFFIX_ADDR:    suffix_addr_r    <= cfg_pwdata[prbg_pkg::PTR_W-1:0];
        prbg_pkg::REG_SUFFIX_SETS:    suffix_sets_r    <= cfg_pwdata[prbg_pkg::PTR_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (cfg_idx)
      prbg_pkg::REG_FIRST_SET_ADDR: cfg_prdata = prbg_pkg::CFG_DATA_W'(first_set_addr_r);
      prbg_pkg::REG_REPEAT_ADDR:    cfg_prdata = prbg_pkg::CFG_DATA_W'(repeat_addr_r);
      prbg_pkg::REG_SUFFIX_ADDR:    cfg_prdata = prbg_pkg::CFG_DATA_W'(suffix_addr_r);
      prbg_pkg::REG_SUFFIX_SETS:    cfg_prdata = prbg_pkg::CFG_DATA_W'(suffix_sets_r);
      default:                      cfg_prdata = '0;
    endcase
  end

  // ---------------- pipeline state ----------------
  prbg_pkg::ptr_t  set_pointer_r, set_pointer_nxt;
  logic            in_suffix_r, in_suffix_nxt;

  logic            b_valid_r;      // count read in flight
  prbg_pkg::ptr_t  b_ptr_r;
  logic            b_suf_r;
  prbg_pkg::byte_t b_draw_r;

  logic            c_valid_r;      // member read in flight
  logic            c_zero_r;
  prbg_pkg::byte_t c_draw_r;

  prbg_pkg::byte_t buf_mem_r [2];
  logic            buf_wp_r, buf_rp_r;
  logic [1:0]      buf_cnt_r;

  // ---------------- accept stage ----------------
  logic            acc, acc_gen, acc_load;
  prbg_pkg::ptr_t  a_ptr0, a_ptr;
  logic            a_suf0, a_suf;
  logic [WIDE_W-1:0] a_wide, ld_wide, m_wide;
  maddr_t          rd1_addr, rd2_addr, wr_addr;

  assign in_ch.ready = !b_valid_r &&
                       ((2'(c_valid_r) + buf_cnt_r) <= 2'd1);
  assign acc      = in_ch.valid && in_ch.ready;
  assign acc_gen  = acc && (in_ch.action == prbg_pkg::ACT_GENERATE);
  assign acc_load = acc && (in_ch.action == prbg_pkg::ACT_LOAD);

  always_comb begin
    a_ptr0 = in_ch.first ? prbg_pkg::ptr_t'(first_set_addr_r) : set_pointer_r;
    a_suf0 = in_ch.first ? 1'b0 : in_suffix_r;
    a_ptr  = a_ptr0;
    a_suf  = a_suf0;
    // jump to the suffix once bytes_left is at or below suffix_sets
    if (!a_suf0 && (in_ch.bytes_left <= prbg_pkg::LEFT_W'(suffix_sets_r))) begin
      a_ptr = suffix_addr_r;
      a_suf = 1'b1;
    end
  end

  assign a_wide   = WIDE_W'(a_ptr);
  assign rd1_addr = a_wide[AW-1:0];
  assign ld_wide  = WIDE_W'(in_ch.table_addr);
  assign wr_addr  = ld_wide[AW-1:0];

  // ---------------- pattern table memory ----------------
  prbg_pkg::byte_t tbl_mem [TABLE_DEPTH];
  prbg_pkg::byte_t rd1_data_r, rd2_data_r;

  always_ff @(posedge clk) begin
    if (acc_load) begin
      tbl_mem[wr_addr] <= in_ch.table_data;
    end
    rd1_data_r <= tbl_mem[rd1_addr];
    rd2_data_r <= tbl_mem[rd2_addr];
  end

  // ---------------- count stage ----------------
  logic [2*prbg_pkg::BYTE_W-1:0] prod;
  prbg_pkg::byte_t               idx;
  logic [SUM_W-1:0]              m_sum;
  prbg_pkg::ptr_t                step_ptr;

  always_comb begin
    prod     = b_draw_r * rd1_data_r;
    idx      = prod[2*prbg_pkg::BYTE_W-1:prbg_pkg::BYTE_W];
    m_sum    = SUM_W'(b_ptr_r) + SUM_W'(1) + SUM_W'(idx);
    m_wide   = WIDE_W'(m_sum);
    rd2_addr = m_wide[AW-1:0];
    // a zero count also steps by one, so one adder serves both cases
    step_ptr = b_ptr_r + prbg_pkg::ptr_t'(rd1_data_r) + prbg_pkg::ptr_t'(1);

    set_pointer_nxt = set_pointer_r;
    in_suffix_nxt   = in_suffix_r;
    if (b_valid_r) begin
      in_suffix_nxt = b_suf_r;
      if (!b_suf_r && (step_ptr == suffix_addr_r)) begin
        set_pointer_nxt = prbg_pkg::ptr_t'(repeat_addr_r);
      end else begin
        set_pointer_nxt = step_ptr;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      set_pointer_r <= '0;
      in_suffix_r   <= 1'b0;
      b_valid_r     <= 1'b0;
      c_valid_r     <= 1'b0;
    end else begin
      set_pointer_r <= set_pointer_nxt;
      in_suffix_r   <= in_suffix_nxt;
      b_valid_r     <= acc_gen;
      c_valid_r     <= b_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (acc_gen) begin
      b_ptr_r  <= a_ptr;
      b_suf_r  <= a_suf;
      b_draw_r <= in_ch.draw;
    end
    if (b_valid_r) begin
      c_zero_r <= (rd1_data_r == '0);
      c_draw_r <= b_draw_r;
    end
  end

  // ---------------- output buffer ----------------
  prbg_pkg::byte_t c_byte;
  logic            buf_push, buf_pop;

  assign c_byte   = c_zero_r ? c_draw_r : rd2_data_r;
  assign buf_push = c_valid_r;
  assign buf_pop  = out_ch.valid && out_ch.ready;

  assign out_ch.valid     = (buf_cnt_r != 2'd0);
  assign out_ch.data_byte = buf_mem_r[buf_rp_r];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      buf_wp_r  <= 1'b0;
      buf_rp_r  <= 1'b0;
      buf_cnt_r <= 2'd0;
    end else begin
      if (buf_push) begin
        buf_wp_r <= !buf_wp_r;
      end
      if (buf_pop) begin
        buf_rp_r <= !buf_rp_r;
      end
      buf_cnt_r <= buf_cnt_r + 2'(buf_push) - 2'(buf_pop);
    end
  end

  always_ff @(posedge clk) begin
    if (buf_push) begin
      buf_mem_r[buf_wp_r] <= c_byte;
    end
  end

  // ---------------- assertions ----------------
  a_count_one_cycle: assert property (@(posedge clk) disable iff (!rst_n)
    b_valid_r |=> !b_valid_r)
    else $error("count stage held an item for more than one cycle");

  a_no_accept_during_count: assert property (@(posedge clk) disable iff (!rst_n)
    b_valid_r |-> !in_ch.ready)
    else $error("input taken before the set pointer was updated");

  a_buffer_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    buf_cnt_r <= 2'd2)
    else $error("output buffer overflow");

  a_push_has_room: assert property (@(posedge clk) disable iff (!rst_n)
    (buf_push && !buf_pop) |-> (buf_cnt_r != 2'd2))
    else $error("byte pushed into a full output buffer");

  a_member_follows_count: assert property (@(posedge clk) disable iff (!rst_n)
    acc_gen |=> ##1 c_valid_r)
    else $error("generated byte lost between stages");

endmodule
